// ===== hw/rtl/jhs_pkg.sv =====
// ============================================================================
// jhs_pkg: shared constants for the Jacobi heat stencil sweep
// Grid limits, fixed-point format, register indexes and reset values.
// ============================================================================
package jhs_pkg;

    // grid geometry and number format
    localparam int MaxSize  = 63;
    localparam int FracBits = 16;
    localparam int PosW     = 6;
    localparam int ValW     = 24;
    localparam int SumW     = ValW + 2;
    localparam int CfgIdxW  = 2;

    typedef logic [PosW-1:0] pos_t;
    typedef logic [ValW-1:0] val_t;
    typedef logic [SumW-1:0] sum_t;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_GRID_SIZE  = 2'd0,
        CFG_HOT_VALUE  = 2'd1,
        CFG_COLD_VALUE = 2'd2
    } cfg_idx_t;

    // reset values: 100.0 hot, 0.0 cold, largest grid
    localparam pos_t SizeReset = PosW'(MaxSize);
    localparam val_t HotReset  = ValW'(100 << FracBits);
    localparam val_t ColdReset = '0;
    localparam pos_t SizeMin   = PosW'(3);

endpackage

// ===== hw/rtl/jacobi_heat_stencil_sweep.sv =====
// ============================================================================
// jacobi_heat_stencil_sweep: one Jacobi five-point sweep over a streamed grid
// Two row stores feed a registered stencil; the bottom row is flushed at the
// end of each frame.
// ============================================================================
// Usage:
//   s_ channel takes the cells of the current grid in row-major order, one
//   item per cycle while s_ready is high. m_ channel returns the cells of the
//   next grid with their row and column; cell (r-1, c) leaves when input cell
//   (r, c) is taken, so the first input row gives no item. The last input cell
//   also starts a flush of the bottom row at cold_value, one item per cycle
//   unless m_ready holds it back, with m_frame_end on the last one.
//   A result is registered at the edge that takes its input item and shows on
//   m_ straight from that register. Input items are taken while s_ready is
//   high; the frame end adds one flush item per grid column (grid_size clamped
//   to 3..63) with s_ready low while the flush runs.
//   Row store reads are registered ahead of the item that needs them, so
//   s_ready stays low after reset until a read has been registered, and in
//   the cycle after each configuration write.
//   cfg_ channel writes grid_size, hot_value or cold_value; it is always ready.
//   Write it only while the block is idle; the block does not enforce this.
//   Reset clears the position counters and flags and loads the configuration
//   registers; row store contents are never used before a frame writes them.
//   When m_ready is low with a result waiting, the result register holds and
//   s_ready drops.
// ============================================================================
module jacobi_heat_stencil_sweep
    import jhs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ValW-1:0]    cfg_data,
    // current grid cells
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ValW-1:0]    s_temperature,
    // next grid cells
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PosW-1:0]    m_cell_row,
    output logic [PosW-1:0]    m_cell_col,
    output logic [ValW-1:0]    m_new_temperature,
    output logic               m_frame_end
);

    // configuration registers
    pos_t grid_size_reg;
    val_t hot_value_reg;
    val_t cold_value_reg;

    // position of the next input item
    pos_t row_reg;
    pos_t col_reg;

    // row stores and their registered read data
    val_t older_mem [MaxSize];
    val_t newer_mem [MaxSize];
    val_t older_rd_reg;
    val_t center_rd_reg;
    val_t right_rd_reg;
    val_t left_reg;
    logic rd_ok_reg;

    // bottom row flush
    logic flush_reg;
    pos_t flush_col_reg;

    // result register
    logic m_valid_reg;
    pos_t m_row_reg;
    pos_t m_col_reg;
    val_t m_temp_reg;
    logic m_end_reg;

    logic   cfg_acc;
    logic   in_acc;
    logic   out_load;
    pos_t   n_eff;
    pos_t   n_last;
    logic   restart;
    pos_t   cur_row;
    pos_t   cur_col;
    logic   col_end;
    logic   row_end;
    pos_t   row_next;
    pos_t   col_next;
    pos_t   rd_col;
    logic [PosW:0] rgt_sum;
    pos_t   rd_rgt;
    sum_t   stencil_sum;
    val_t   cell_value;
    logic   flush_last;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // clamp the grid size into its legal range
    always_comb begin
        n_eff = grid_size_reg;
        if (grid_size_reg < SizeMin) begin
            n_eff = SizeMin;
        end
        if ({1'b0, grid_size_reg} > (PosW+1)'(MaxSize)) begin
            n_eff = PosW'(MaxSize);
        end
    end
    assign n_last = n_eff - PosW'(1);

    // current position, restarting the frame when outside the grid
    assign restart = (row_reg >= n_eff) || (col_reg >= n_eff);
    assign cur_row = restart ? '0 : row_reg;
    assign cur_col = restart ? '0 : col_reg;
    assign col_end = (cur_col == n_last);
    assign row_end = (cur_row == n_last);

    // advance the position counters
    always_comb begin
        col_next = cur_col + PosW'(1);
        row_next = cur_row;
        if (col_end) begin
            col_next = '0;
            row_next = row_end ? '0 : cur_row + PosW'(1);
        end
    end

    // handshakes
    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = rd_ok_reg && !flush_reg && out_load;
    assign in_acc   = s_valid && s_ready;

    // read addresses for the item that comes next
    assign rd_col  = in_acc ? col_next : cur_col;
    assign rgt_sum = {1'b0, rd_col} + (PosW+1)'(1);
    assign rd_rgt  = (rgt_sum >= (PosW+1)'(MaxSize)) ? '0 : rgt_sum[PosW-1:0];

    // five-point stencil: up, left, right, down
    assign stencil_sum = SumW'(older_rd_reg) + SumW'(left_reg)
                       + SumW'(right_rd_reg) + SumW'(s_temperature);

    always_comb begin
        if (cur_row == PosW'(1)) begin
            cell_value = hot_value_reg;
        end else if (cur_col == '0 || col_end) begin
            cell_value = cold_value_reg;
        end else begin
            cell_value = stencil_sum[SumW-1:2];
        end
    end

    assign flush_last = (flush_col_reg == n_last);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg  <= SizeReset;
            hot_value_reg  <= HotReset;
            cold_value_reg <= ColdReset;
        end else if (cfg_acc) begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRID_SIZE:  grid_size_reg  <= cfg_data[PosW-1:0];
                CFG_HOT_VALUE:  hot_value_reg  <= cfg_data;
                CFG_COLD_VALUE: cold_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // row stores: move the center into the older row, store the new cell
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            older_mem[cur_col] <= center_rd_reg;
            newer_mem[cur_col] <= s_temperature;
        end
        older_rd_reg  <= older_mem[rd_col];
        center_rd_reg <= newer_mem[rd_col];
        right_rd_reg  <= newer_mem[rd_rgt];
    end

    // hold the previous center as the left neighbor
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            left_reg <= center_rd_reg;
        end
    end

    // read data is good in the cycle after the address settles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ok_reg <= 1'b0;
        end else begin
            rd_ok_reg <= !cfg_acc;
        end
    end

    // position counters and flush control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            flush_reg     <= 1'b0;
            flush_col_reg <= '0;
        end else begin
            if (in_acc) begin
                row_reg <= row_next;
                col_reg <= col_next;
                if (col_end && row_end) begin
                    flush_reg     <= 1'b1;
                    flush_col_reg <= '0;
                end
            end else if (flush_reg && out_load) begin
                flush_col_reg <= flush_col_reg + PosW'(1);
                if (flush_last) begin
                    flush_reg <= 1'b0;
                end
            end
        end
    end

    // result register: flush items, stencil items, or drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= flush_reg || (in_acc && cur_row != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (flush_reg) begin
                m_row_reg  <= n_last;
                m_col_reg  <= flush_col_reg;
                m_temp_reg <= cold_value_reg;
                m_end_reg  <= flush_last;
            end else if (in_acc) begin
                m_row_reg  <= cur_row - PosW'(1);
                m_col_reg  <= cur_col;
                m_temp_reg <= cell_value;
                m_end_reg  <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cell_row        = m_row_reg;
    assign m_cell_col        = m_col_reg;
    assign m_new_temperature = m_temp_reg;
    assign m_frame_end       = m_end_reg;

`ifndef SYNTH
    // no input item is taken while the bottom row flushes
    assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> !s_ready)
        else $error("input item taken during flush");

    // the last cell of a frame starts the flush
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && col_end && row_end) |=> flush_reg)
        else $error("frame end did not start the flush");

    // a configuration write invalidates the prefetched row data
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> !s_ready)
        else $error("input item taken on stale row data");

    // frame end marks the bottom right corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_end_reg) |-> (m_row_reg == m_col_reg))
        else $error("frame end away from the last cell");
`endif

endmodule
